/* rtl/core/cst_pkg.sv */
// Shared types, constants and decode functions of the C-subset token scanner.
// No dependencies; every other file depends on it.
package cst_pkg;

	localparam int LINE_BITS       = 20;
	localparam int LINE_W          = LINE_BITS;
	localparam int KEYWORD_MAX_LEN = 8;
	localparam int KIND_W          = 7;
	localparam int ERR_W           = 2;
	localparam int LEN_W           = 4;
	localparam int NUM_W           = 32;
	localparam int FIFO_DEPTH      = 4;

	localparam logic [NUM_W-1:0] NUM_MAX = 32'd2147483647;

	typedef enum logic [3:0] {
		M_IDLE, M_WORD, M_NUM, M_BAR, M_EQ, M_AMP, M_BANG, M_LT, M_GT,
		M_MINUS, M_PLUS, M_SLASH, M_COMM, M_STAR, M_STR, M_CHR
	} mode_t;

	localparam logic [KIND_W-1:0] K_ID    = 7'd0;
	localparam logic [KIND_W-1:0] K_NUM   = 7'd1;
	localparam logic [KIND_W-1:0] K_KW    = 7'd2;
	localparam logic [KIND_W-1:0] K_OR    = 7'd34;
	localparam logic [KIND_W-1:0] K_ASG   = 7'd35;
	localparam logic [KIND_W-1:0] K_EQEQ  = 7'd36;
	localparam logic [KIND_W-1:0] K_LAND  = 7'd37;
	localparam logic [KIND_W-1:0] K_AMP   = 7'd38;
	localparam logic [KIND_W-1:0] K_NE    = 7'd39;
	localparam logic [KIND_W-1:0] K_NOT   = 7'd40;
	localparam logic [KIND_W-1:0] K_LE    = 7'd41;
	localparam logic [KIND_W-1:0] K_LT    = 7'd42;
	localparam logic [KIND_W-1:0] K_GE    = 7'd43;
	localparam logic [KIND_W-1:0] K_GT    = 7'd44;
	localparam logic [KIND_W-1:0] K_DEC   = 7'd45;
	localparam logic [KIND_W-1:0] K_ARROW = 7'd46;
	localparam logic [KIND_W-1:0] K_MINUS = 7'd47;
	localparam logic [KIND_W-1:0] K_INC   = 7'd48;
	localparam logic [KIND_W-1:0] K_PLUS  = 7'd49;
	localparam logic [KIND_W-1:0] K_MUL   = 7'd50;
	localparam logic [KIND_W-1:0] K_MOD   = 7'd51;
	localparam logic [KIND_W-1:0] K_COLON = 7'd52;
	localparam logic [KIND_W-1:0] K_SEMI  = 7'd53;
	localparam logic [KIND_W-1:0] K_LPAR  = 7'd54;
	localparam logic [KIND_W-1:0] K_RPAR  = 7'd55;
	localparam logic [KIND_W-1:0] K_LBRK  = 7'd56;
	localparam logic [KIND_W-1:0] K_RBRK  = 7'd57;
	localparam logic [KIND_W-1:0] K_LBRC  = 7'd58;
	localparam logic [KIND_W-1:0] K_RBRC  = 7'd59;
	localparam logic [KIND_W-1:0] K_DOT   = 7'd60;
	localparam logic [KIND_W-1:0] K_COMMA = 7'd61;
	localparam logic [KIND_W-1:0] K_DIV   = 7'd62;
	localparam logic [KIND_W-1:0] K_STR   = 7'd63;
	localparam logic [KIND_W-1:0] K_CHR   = 7'd64;
	localparam logic [KIND_W-1:0] K_END   = 7'd65;

	localparam logic [ERR_W-1:0] E_NONE = 2'd0;
	localparam logic [ERR_W-1:0] E_BIG  = 2'd1;
	localparam logic [ERR_W-1:0] E_STR  = 2'd2;
	localparam logic [ERR_W-1:0] E_CHR  = 2'd3;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [LINE_W-1:0] line;
		logic [ERR_W-1:0]  err;
		logic              last;
	} res_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// Kind of a byte that is a token on its own, zero when it is not one.
	function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
		case (c)
			8'h2A:   return K_MUL;
			8'h25:   return K_MOD;
			8'h3A:   return K_COLON;
			8'h3B:   return K_SEMI;
			8'h28:   return K_LPAR;
			8'h29:   return K_RPAR;
			8'h5B:   return K_LBRK;
			8'h5D:   return K_RBRK;
			8'h7B:   return K_LBRC;
			8'h7D:   return K_RBRC;
			8'h2E:   return K_DOT;
			8'h2C:   return K_COMMA;
			default: return K_ID;
		endcase
	endfunction

	function automatic mode_t start_mode(input logic [7:0] c);
		if (is_alpha(c)) return M_WORD;
		if (is_digit(c)) return M_NUM;
		case (c)
			CH_BAR:    return M_BAR;
			CH_EQ:     return M_EQ;
			CH_AMP:    return M_AMP;
			CH_BANG:   return M_BANG;
			CH_LT:     return M_LT;
			CH_GT:     return M_GT;
			CH_MINUS:  return M_MINUS;
			CH_PLUS:   return M_PLUS;
			CH_SLASH:  return M_SLASH;
			CH_DQUOTE: return M_STR;
			CH_SQUOTE: return M_CHR;
			default:   return M_IDLE;
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] lone_kind(input mode_t m);
		case (m)
			M_BAR:   return K_OR;
			M_EQ:    return K_ASG;
			M_AMP:   return K_AMP;
			M_BANG:  return K_NOT;
			M_LT:    return K_LT;
			M_GT:    return K_GT;
			M_MINUS: return K_MINUS;
			M_PLUS:  return K_PLUS;
			default: return K_DIV;
		endcase
	endfunction

	// Kind of a two-byte operator, zero when the byte does not combine.
	function automatic logic [KIND_W-1:0] pair_kind(input mode_t m, input logic [7:0] c);
		case (m)
			M_BAR:   return (c == CH_BAR) ? K_OR : K_ID;
			M_EQ:    return (c == CH_EQ) ? K_EQEQ : K_ID;
			M_AMP:   return (c == CH_AMP) ? K_LAND : K_ID;
			M_BANG:  return (c == CH_EQ) ? K_NE : K_ID;
			M_LT:    return (c == CH_EQ) ? K_LE : K_ID;
			M_GT:    return (c == CH_EQ) ? K_GE : K_ID;
			M_MINUS: return (c == CH_MINUS) ? K_DEC : ((c == CH_GT) ? K_ARROW : K_ID);
			M_PLUS:  return (c == CH_PLUS) ? K_INC : K_ID;
			default: return K_ID;
		endcase
	endfunction

	// Keyword text, last byte in the low bits.
	function automatic logic [63:0] kw_text(input int idx);
		case (idx)
			0:  return 64'("auto");
			1:  return 64'("break");
			2:  return 64'("case");
			3:  return 64'("char");
			4:  return 64'("const");
			5:  return 64'("continue");
			6:  return 64'("default");
			7:  return 64'("do");
			8:  return 64'("double");
			9:  return 64'("else");
			10: return 64'("enum");
			11: return 64'("extern");
			12: return 64'("float");
			13: return 64'("for");
			14: return 64'("goto");
			15: return 64'("if");
			16: return 64'("int");
			17: return 64'("long");
			18: return 64'("register");
			19: return 64'("return");
			20: return 64'("short");
			21: return 64'("signed");
			22: return 64'("sizeof");
			23: return 64'("static");
			24: return 64'("struct");
			25: return 64'("switch");
			26: return 64'("typedef");
			27: return 64'("union");
			28: return 64'("unsigned");
			29: return 64'("void");
			30: return 64'("volatile");
			default: return 64'("while");
		endcase
	endfunction

	function automatic int kw_len(input int idx);
		logic [63:0] t;
		int n;
		t = kw_text(idx);
		n = 0;
		for (int j = 0; j < 8; j++)
			if (t[8*j +: 8] != 8'h00) n = j + 1;
		return n;
	endfunction

endpackage

/* rtl/core/cst_if.sv */
// Valid/ready channel interfaces for source bytes and scanned tokens.
// Depends on cst_pkg for field widths.
interface cst_char_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] char_code;
	modport source(output valid, action, char_code, input ready);
	modport sink(input valid, action, char_code, output ready);
endinterface

interface cst_tok_if;
	logic                       valid;
	logic                       ready;
	logic [cst_pkg::KIND_W-1:0] token_kind;
	logic [cst_pkg::LINE_W-1:0] line_number;
	logic [cst_pkg::ERR_W-1:0]  error_code;
	logic                       last_of_run;
	modport source(output valid, token_kind, line_number, error_code, last_of_run,
		input ready);
	modport sink(input valid, token_kind, line_number, error_code, last_of_run,
		output ready);
endinterface

/* rtl/core/cst_kw_match.sv */
// Keyword lookup over the buffered word: compares against all 32 keywords at once.
// Depends on cst_pkg.
module cst_kw_match (
	input  logic [7:0]                 buf_bytes [cst_pkg::KEYWORD_MAX_LEN],
	input  logic [cst_pkg::LEN_W-1:0]  len,
	output logic [cst_pkg::KIND_W-1:0] kind
);
	import cst_pkg::*;

	always_comb begin
		logic same;
		logic [63:0] t;
		int kl;
		kind = K_ID;
		for (int i = 31; i >= 0; i--) begin
			t = kw_text(i);
			kl = kw_len(i);
			same = (len == LEN_W'(kl));
			for (int j = 0; j < KEYWORD_MAX_LEN; j++)
				if (j < kl && buf_bytes[j] != t[8*(kl-1-j) +: 8]) same = 1'b0;
			if (same) kind = K_KW + KIND_W'(i);
		end
	end
endmodule

/* rtl/core/cst_res_fifo.sv */
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on cst_pkg.
module cst_res_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_cnt,
	input  cst_pkg::res_t push0,
	input  cst_pkg::res_t push1,
	input  logic          pop,
	output cst_pkg::res_t head,
	output logic          not_empty,
	output logic          room2
);
	import cst_pkg::*;

	res_t       mem_q [FIFO_DEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign head      = mem_q[rp_q];
	assign not_empty = (cnt_q != 3'd0);
	assign room2     = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wp_q] <= push0;
		if (push_cnt == 2'd2) mem_q[wp_q + 2'd1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + push_cnt;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_cnt} - {2'b00, pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("result queue over capacity");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> (cnt_q <= 3'd2)) else $error("push without room");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
`endif
endmodule

/* rtl/core/c_subset_token_scanner.sv */
// Top level of the C-subset token scanner: scan state, token decode, result queue.
// Depends on cst_pkg, cst_if, cst_kw_match and cst_res_fifo.
//
// channel  role   payload
// chars    sink   action, char_code (one source byte or end of input)
// tokens   source token_kind, line_number, error_code, last_of_run
//
// One byte is taken per cycle; its zero, one or two tokens are decided in the
// same cycle from the scan registers and pushed into a four-entry queue.
// Tokens leave the queue one per cycle while tokens.ready is high.
// chars.ready is high while the queue has room for two.
// Reset clears the scan state to idle with line 1; the queue starts empty.
module c_subset_token_scanner (
	input logic        clk,
	input logic        arst_n,
	cst_char_if.sink   chars,
	cst_tok_if.source  tokens
);
	import cst_pkg::*;

	localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

	// scan registers
	mode_t                mode_q, mode_d;
	logic [7:0]           wbuf_q [KEYWORD_MAX_LEN];
	logic [LEN_W-1:0]     len_q, len_d;
	logic [NUM_W-1:0]     val_q, val_d;
	logic                 big_q, big_d, oct_q, oct_d, halt_q, halt_d, esc_q, esc_d;
	logic [LINE_BITS-1:0] line_q, line_d, line_inc;

	logic       acc, is_end, alnum;
	logic [7:0] c;
	logic       wr_buf0, wr_bufn;
	logic [KIND_W-1:0] word_kind, sgl, pk;

	// token slots: A is the pending token being closed, B a one-byte token or the end token
	logic              a_v, b_v, a_newline;
	logic [KIND_W-1:0] a_kind, b_kind;
	logic [ERR_W-1:0]  a_err;
	res_t              r0, r1;
	logic [1:0]        push_cnt;
	res_t              head;
	logic              room2;

	assign acc      = chars.valid && chars.ready;
	assign is_end   = chars.action;
	assign c        = chars.char_code;
	assign alnum    = is_alpha(c) || is_digit(c);
	assign sgl      = single_kind(c);
	assign pk       = pair_kind(mode_q, c);
	assign line_inc = (line_q < LINE_TOP) ? line_q + 1'b1 : line_q;

	cst_kw_match u_kw (.buf_bytes(wbuf_q), .len(len_q), .kind(word_kind));

	// next scan state
	always_comb begin
		logic start;
		logic [34:0] prod;
		logic [3:0]  d;
		mode_d  = mode_q;
		len_d   = len_q;
		val_d   = val_q;
		big_d   = big_q;
		oct_d   = oct_q;
		halt_d  = halt_q;
		esc_d   = esc_q;
		line_d  = line_q;
		wr_buf0 = 1'b0;
		wr_bufn = 1'b0;
		start   = 1'b0;
		d       = c[3:0];
		prod    = '0;
		if (is_end) begin
			mode_d = M_IDLE;
			len_d  = '0;
			val_d  = '0;
			big_d  = 1'b0;
			oct_d  = 1'b0;
			halt_d = 1'b0;
			esc_d  = 1'b0;
			line_d = LINE_BITS'(1);
		end else begin
			unique case (mode_q)
				M_WORD: begin
					if (alnum) begin
						wr_bufn = (len_q < LEN_W'(KEYWORD_MAX_LEN));
						len_d = (len_q < LEN_W'(KEYWORD_MAX_LEN)) ? len_q + 1'b1
							: LEN_W'(KEYWORD_MAX_LEN + 1);
					end else start = 1'b1;
				end
				M_NUM: begin
					if (is_digit(c)) begin
						if (halt_q) begin
							// digits past an octal stop are dropped
						end else if (oct_q && d >= 4'd8) begin
							halt_d = 1'b1;
						end else begin
							prod = oct_q ? {val_q, 3'b000}
								: ({val_q, 3'b000} + {2'b00, val_q, 1'b0});
							prod = prod + 35'(d);
							if (prod > 35'(NUM_MAX)) begin
								big_d = 1'b1;
								val_d = NUM_MAX;
							end else val_d = prod[NUM_W-1:0];
						end
					end else start = 1'b1;
				end
				M_SLASH: begin
					if (c == CH_STAR) mode_d = M_COMM;
					else start = 1'b1;
				end
				M_BAR, M_EQ, M_AMP, M_BANG, M_LT, M_GT, M_MINUS, M_PLUS: begin
					if (pk != K_ID) mode_d = M_IDLE;
					else start = 1'b1;
				end
				M_COMM, M_STAR: begin
					if (mode_q == M_STAR && c == CH_SLASH) mode_d = M_IDLE;
					else if (c == CH_STAR) mode_d = M_STAR;
					else begin
						if (c == CH_NL) line_d = line_inc;
						mode_d = M_COMM;
					end
				end
				M_STR, M_CHR: begin
					if (esc_q) begin
						esc_d = 1'b0;
						if (c == CH_NL) line_d = line_inc;
					end else if (c == CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (c == (mode_q == M_STR ? CH_DQUOTE : CH_SQUOTE)) begin
						mode_d = M_IDLE;
					end else if (c == CH_NL) begin
						line_d = line_inc;
						mode_d = M_IDLE;
					end
				end
				default: start = 1'b1;
			endcase
			if (start) begin
				mode_d = start_mode(c);
				if (c == CH_NL) line_d = line_inc;
				if (is_alpha(c)) begin
					wr_buf0 = 1'b1;
					len_d   = LEN_W'(1);
				end else if (is_digit(c)) begin
					val_d  = NUM_W'(d);
					oct_d  = (d == 4'd0);
					big_d  = 1'b0;
					halt_d = 1'b0;
				end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
					esc_d = 1'b0;
				end
			end
		end
	end

	// tokens produced by this byte
	always_comb begin
		logic starts;
		a_v       = 1'b0;
		a_kind    = K_ID;
		a_err     = E_NONE;
		a_newline = 1'b0;
		b_v       = 1'b0;
		b_kind    = sgl;
		starts    = 1'b0;
		if (is_end) begin
			b_v    = 1'b1;
			b_kind = K_END;
			unique case (mode_q)
				M_WORD: begin a_v = 1'b1; a_kind = word_kind; end
				M_NUM: begin
					a_v = 1'b1; a_kind = K_NUM; a_err = big_q ? E_BIG : E_NONE;
				end
				M_BAR, M_EQ, M_AMP, M_BANG, M_LT, M_GT, M_MINUS, M_PLUS, M_SLASH: begin
					a_v = 1'b1; a_kind = lone_kind(mode_q);
				end
				M_STR: begin a_v = 1'b1; a_kind = K_STR; a_err = E_STR; end
				M_CHR: begin a_v = 1'b1; a_kind = K_CHR; a_err = E_CHR; end
				default: ;
			endcase
		end else begin
			unique case (mode_q)
				M_WORD: if (!alnum) begin
					a_v = 1'b1; a_kind = word_kind; starts = 1'b1;
				end
				M_NUM: if (!is_digit(c)) begin
					a_v = 1'b1; a_kind = K_NUM; a_err = big_q ? E_BIG : E_NONE;
					starts = 1'b1;
				end
				M_SLASH: if (c != CH_STAR) begin
					a_v = 1'b1; a_kind = K_DIV; starts = 1'b1;
				end
				M_BAR, M_EQ, M_AMP, M_BANG, M_LT, M_GT, M_MINUS, M_PLUS: begin
					a_v = 1'b1;
					if (pk != K_ID) a_kind = pk;
					else begin
						a_kind = lone_kind(mode_q);
						starts = 1'b1;
					end
				end
				M_STR, M_CHR: begin
					if (!esc_q && c != CH_BSLASH) begin
						if (c == (mode_q == M_STR ? CH_DQUOTE : CH_SQUOTE)) begin
							a_v = 1'b1;
							a_kind = (mode_q == M_STR) ? K_STR : K_CHR;
						end else if (c == CH_NL) begin
							// unterminated literal: reported on the following line
							a_v = 1'b1;
							a_newline = 1'b1;
							a_kind = (mode_q == M_STR) ? K_STR : K_CHR;
							a_err  = (mode_q == M_STR) ? E_STR : E_CHR;
						end
					end
				end
				M_COMM, M_STAR: ;
				default: starts = 1'b1;
			endcase
			b_v = starts && (sgl != K_ID);
		end
	end

	// pack into queue slots; line is the count before this byte's newline, except for an unterminated literal
	always_comb begin
		res_t ra, rb;
		ra.kind = a_kind;
		ra.line = LINE_W'(a_newline ? line_inc : line_q);
		ra.err  = a_err;
		ra.last = !b_v;
		rb.kind = b_kind;
		rb.line = LINE_W'(line_q);
		rb.err  = E_NONE;
		rb.last = 1'b1;
		r0 = a_v ? ra : rb;
		r1 = rb;
		push_cnt = acc ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
	end

	cst_res_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push_cnt(push_cnt), .push0(r0), .push1(r1),
		.pop(tokens.valid && tokens.ready), .head(head), .not_empty(tokens.valid),
		.room2(room2)
	);

	assign chars.ready        = room2;
	assign tokens.token_kind  = head.kind;
	assign tokens.line_number = head.line;
	assign tokens.error_code  = head.err;
	assign tokens.last_of_run = head.last;

	// word buffer: no reset, read only below the current length
	always_ff @(posedge clk) begin
		if (acc && !is_end) begin
			if (wr_buf0) wbuf_q[0] <= c;
			if (wr_bufn) wbuf_q[len_q[2:0]] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			len_q  <= '0;
			val_q  <= '0;
			big_q  <= 1'b0;
			oct_q  <= 1'b0;
			halt_q <= 1'b0;
			esc_q  <= 1'b0;
			line_q <= LINE_BITS'(1);
		end else if (acc) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			val_q  <= val_d;
			big_q  <= big_d;
			oct_q  <= oct_d;
			halt_q <= halt_d;
			esc_q  <= esc_d;
			line_q <= line_d;
		end
	end

`ifndef ASSERT_OFF
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_end) |=> (mode_q == M_IDLE && line_q == LINE_BITS'(1)))
		else $error("end of input did not restore scan state");
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0) else $error("line count reached zero");
	a_end_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_end) |-> (push_cnt != 2'd0)) else $error("end of input lost");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(KEYWORD_MAX_LEN + 1)) else $error("word length overrun");
`endif
endmodule
